// File: rtl/lsmc_pkg.sv
// Package with the shared types, codes, constants and timer helper of the LED show controller.
`timescale 1ns / 1ps

package lsmc_pkg;

  // Pattern counts per family.
  localparam int NUM_ANIM   = 7;
  localparam int NUM_BITMAP = 8;

  // Request codes carried by req_type.
  localparam logic [2:0] REQ_CLICK       = 3'd0;
  localparam logic [2:0] REQ_DOUBLE      = 3'd1;
  localparam logic [2:0] REQ_MULTI       = 3'd2;
  localparam logic [2:0] REQ_PRESS_START = 3'd3;
  localparam logic [2:0] REQ_PRESS_STOP  = 3'd4;
  localparam logic [2:0] REQ_TICK        = 3'd5;

  // Configuration register indexes.
  localparam logic [2:0] CFG_BRIGHT_PERIOD = 3'd0;
  localparam logic [2:0] CFG_FRAME_PERIOD  = 3'd1;
  localparam logic [2:0] CFG_ANIM_HOLD     = 3'd2;
  localparam logic [2:0] CFG_BITMAP_HOLD   = 3'd3;
  localparam logic [2:0] CFG_FAMILY_HOLD   = 3'd4;
  localparam logic [2:0] CFG_MINUTE_TICKS  = 3'd5;
  localparam logic [2:0] CFG_SLEEP_MINUTES = 3'd6;
  localparam logic [2:0] CFG_FRAME_COUNTS  = 3'd7;

  // Brightness ramp and click constants.
  localparam logic [7:0] BRIGHT_STEP  = 8'd5;
  localparam logic [7:0] BRIGHT_TOP   = 8'd250;
  localparam logic [7:0] BRIGHT_FLOOR = 8'd10;
  localparam logic [7:0] BRIGHT_RESET = 8'd10;
  localparam logic [3:0] CLICKS_AUTO  = 4'd3;
  localparam logic [3:0] CLICKS_OFF   = 4'd4;
  localparam logic [7:0] MINUTES_MAX  = 8'd255;

  // Configuration register file contents.
  typedef struct packed {
    logic [7:0]  bright_period_ticks;
    logic [7:0]  frame_period_ticks;
    logic [15:0] anim_hold_ticks;
    logic [15:0] bitmap_hold_ticks;
    logic [15:0] family_hold_ticks;
    logic [11:0] minute_ticks;
    logic [7:0]  sleep_minutes;
    logic [31:0] frame_counts;
  } cfg_t;

  // One result item.
  typedef struct packed {
    logic       display_on;
    logic       family;
    logic [2:0] pattern_index;
    logic [3:0] frame_index;
    logic [7:0] base_hue;
    logic [7:0] brightness_level;
    logic       auto_mode;
    logic       show_banner;
  } res_t;

  // Outcome of one timer step.
  typedef struct packed {
    logic        hit;
    logic [15:0] count;
  } timer_t;

  // A timer fires when its count plus one reaches the period; a period of zero acts as one.
  function automatic timer_t timer_step(input logic [15:0] cnt, input logic [15:0] period);
    logic [16:0] c;
    logic [16:0] p;
    timer_t      r;
    c = {1'b0, cnt} + 17'd1;
    p = (period == 16'd0) ? 17'd1 : {1'b0, period};
    r.hit   = (c >= p);
    r.count = r.hit ? 16'd0 : c[15:0];
    return r;
  endfunction

endpackage

// File: rtl/lsmc_req_if.sv
// Channel interface for request items (button events and ticks).
`timescale 1ns / 1ps

interface lsmc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [3:0] click_count;

  modport source (output valid, output req_type, output click_count, input ready);
  modport sink (input valid, input req_type, input click_count, output ready);
endinterface

// File: rtl/lsmc_res_if.sv
// Channel interface for result items (display state).
`timescale 1ns / 1ps

interface lsmc_res_if;
  logic       valid;
  logic       ready;
  logic       display_on;
  logic       family;
  logic [2:0] pattern_index;
  logic [3:0] frame_index;
  logic [7:0] base_hue;
  logic [7:0] brightness_level;
  logic       auto_mode;
  logic       show_banner;

  modport source (output valid, output display_on, output family, output pattern_index,
                  output frame_index, output base_hue, output brightness_level,
                  output auto_mode, output show_banner, input ready);
  modport sink (input valid, input display_on, input family, input pattern_index,
                input frame_index, input base_hue, input brightness_level,
                input auto_mode, input show_banner, output ready);
endinterface

// File: rtl/lsmc_cfg_if.sv
// Write channel interface for the configuration registers.
`timescale 1ns / 1ps

interface lsmc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/lsmc_cfg_regs.sv
// Configuration register file of the LED show controller.
`timescale 1ns / 1ps

module lsmc_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  lsmc_cfg_if.sink         cfg,
  output lsmc_pkg::cfg_t   regs
);

  // Writes are always taken.
  assign cfg.ready = 1'b1;

  // Register writes, truncated to each register's width.
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.bright_period_ticks <= 8'd5;
      regs.frame_period_ticks  <= 8'd10;
      regs.anim_hold_ticks     <= 16'd1500;
      regs.bitmap_hold_ticks   <= 16'd500;
      regs.family_hold_ticks   <= 16'd30000;
      regs.minute_ticks        <= 12'd3000;
      regs.sleep_minutes       <= 8'd60;
      regs.frame_counts        <= 32'd0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        lsmc_pkg::CFG_BRIGHT_PERIOD: regs.bright_period_ticks <= cfg.data[7:0];
        lsmc_pkg::CFG_FRAME_PERIOD:  regs.frame_period_ticks  <= cfg.data[7:0];
        lsmc_pkg::CFG_ANIM_HOLD:     regs.anim_hold_ticks     <= cfg.data[15:0];
        lsmc_pkg::CFG_BITMAP_HOLD:   regs.bitmap_hold_ticks   <= cfg.data[15:0];
        lsmc_pkg::CFG_FAMILY_HOLD:   regs.family_hold_ticks   <= cfg.data[15:0];
        lsmc_pkg::CFG_MINUTE_TICKS:  regs.minute_ticks        <= cfg.data[11:0];
        lsmc_pkg::CFG_SLEEP_MINUTES: regs.sleep_minutes       <= cfg.data[7:0];
        lsmc_pkg::CFG_FRAME_COUNTS:  regs.frame_counts        <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/lsmc_core.sv
// Mode state registers and the next-state logic applied for one item.
`timescale 1ns / 1ps

module lsmc_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             fire,
  input  logic [2:0]       req_type,
  input  logic [3:0]       click_count,
  input  lsmc_pkg::cfg_t   regs,
  output lsmc_pkg::res_t   result
);

  typedef struct packed {
    logic        on_flag;
    logic        family_sel;
    logic [2:0]  pattern_reg;
    logic [3:0]  frame_reg;
    logic [7:0]  hue_reg;
    logic [7:0]  bright_reg;
    logic        auto_flag;
    logic        banner_pending;
    logic        ramp_active;
    logic        ramp_up;
    logic [7:0]  minutes_run;
    logic [7:0]  bright_cnt;
    logic [7:0]  frame_cnt;
    logic [15:0] pattern_cnt;
    logic [15:0] family_cnt;
    logic [11:0] minute_cnt;
  } state_t;

  state_t st;
  state_t st_next;
  logic   banner;

  // Pattern advance: wakes the display if off, else steps the pattern with a per-family wrap.
  function automatic state_t advance(input state_t s);
    state_t      r;
    logic [3:0]  limit;
    logic [3:0]  p1;
    r     = s;
    limit = s.family_sel ? 4'(lsmc_pkg::NUM_BITMAP) : 4'(lsmc_pkg::NUM_ANIM);
    p1    = {1'b0, s.pattern_reg} + 4'd1;
    if (!s.on_flag) begin
      r.on_flag = 1'b1;
    end else begin
      if (s.family_sel) begin
        r.frame_reg = 4'd0;
      end
      r.pattern_reg = (p1 >= limit) ? 3'd0 : p1[2:0];
    end
    return r;
  endfunction

  // Next state for the item in flight.
  always_comb begin
    lsmc_pkg::timer_t tb;
    lsmc_pkg::timer_t tf;
    lsmc_pkg::timer_t tp;
    lsmc_pkg::timer_t tfam;
    lsmc_pkg::timer_t tm;
    logic [3:0]       fcount;
    logic [4:0]       f1;
    state_t           s;
    s      = st;
    banner = 1'b0;
    fcount = '0;
    f1     = '0;
    tb     = '0;
    tf     = '0;
    tp     = '0;
    tfam   = '0;
    tm     = '0;
    unique case (req_type)
      lsmc_pkg::REQ_CLICK: begin
        s = advance(s);
      end
      lsmc_pkg::REQ_DOUBLE: begin
        s.family_sel  = ~s.family_sel;
        s.pattern_reg = 3'd0;
      end
      lsmc_pkg::REQ_MULTI: begin
        if (!s.on_flag) begin
          s.on_flag = 1'b1;
        end else if (click_count == lsmc_pkg::CLICKS_AUTO) begin
          s.auto_flag      = ~s.auto_flag;
          s.banner_pending = 1'b1;
        end else if (click_count == lsmc_pkg::CLICKS_OFF) begin
          s.on_flag = 1'b0;
        end
      end
      lsmc_pkg::REQ_PRESS_START: begin
        if (s.on_flag) begin
          s.ramp_active = 1'b1;
        end
      end
      lsmc_pkg::REQ_PRESS_STOP: begin
        if (s.on_flag) begin
          s.ramp_active = 1'b0;
          s.ramp_up     = ~s.ramp_up;
        end
      end
      lsmc_pkg::REQ_TICK: begin
        // Banner release, or runtime cleared while the display is off.
        if (s.on_flag && s.banner_pending) begin
          banner           = 1'b1;
          s.banner_pending = 1'b0;
        end else if (!s.on_flag) begin
          s.minutes_run = 8'd0;
        end
        s.hue_reg = s.hue_reg + 8'd1;

        // Brightness ramp while the long press is held.
        tb = lsmc_pkg::timer_step({8'd0, s.bright_cnt}, {8'd0, regs.bright_period_ticks});
        s.bright_cnt = tb.count[7:0];
        if (tb.hit && s.ramp_active && s.on_flag) begin
          if (s.ramp_up && s.bright_reg <= lsmc_pkg::BRIGHT_TOP) begin
            s.bright_reg = s.bright_reg + lsmc_pkg::BRIGHT_STEP;
          end else if (!s.ramp_up && s.bright_reg >= lsmc_pkg::BRIGHT_FLOOR) begin
            s.bright_reg = s.bright_reg - lsmc_pkg::BRIGHT_STEP;
          end
        end

        // Bitmap frame stepping.
        tf = lsmc_pkg::timer_step({8'd0, s.frame_cnt}, {8'd0, regs.frame_period_ticks});
        s.frame_cnt = tf.count[7:0];
        fcount = regs.frame_counts[{s.pattern_reg, 2'b00} +: 4];
        f1     = {1'b0, s.frame_reg} + 5'd1;
        if (tf.hit) begin
          if (s.family_sel) begin
            s.frame_reg = (f1 >= {1'b0, fcount}) ? 4'd0 : f1[3:0];
          end else begin
            s.frame_reg = 4'd0;
          end
        end

        // Automatic pattern change.
        tp = lsmc_pkg::timer_step(s.pattern_cnt,
                                  s.family_sel ? regs.bitmap_hold_ticks : regs.anim_hold_ticks);
        s.pattern_cnt = tp.count;
        if (tp.hit && s.on_flag && s.auto_flag) begin
          s = advance(s);
        end

        // Automatic family change.
        tfam = lsmc_pkg::timer_step(s.family_cnt, regs.family_hold_ticks);
        s.family_cnt = tfam.count;
        if (tfam.hit && s.on_flag && s.auto_flag) begin
          s.family_sel  = ~s.family_sel;
          s.pattern_reg = 3'd0;
        end

        // Runtime minutes and auto-off.
        tm = lsmc_pkg::timer_step({4'd0, s.minute_cnt}, {4'd0, regs.minute_ticks});
        s.minute_cnt = tm.count[11:0];
        if (tm.hit) begin
          if (s.on_flag && s.minutes_run < lsmc_pkg::MINUTES_MAX) begin
            s.minutes_run = s.minutes_run + 8'd1;
          end
          if (s.minutes_run >= regs.sleep_minutes) begin
            s.on_flag = 1'b0;
          end
        end
      end
      default: ;
    endcase
    st_next = s;
  end

  // Result fields follow the state after the item.
  assign result.display_on       = st_next.on_flag;
  assign result.family           = st_next.family_sel;
  assign result.pattern_index    = st_next.pattern_reg;
  assign result.frame_index      = st_next.frame_reg;
  assign result.base_hue         = st_next.hue_reg;
  assign result.brightness_level = st_next.bright_reg;
  assign result.auto_mode        = st_next.auto_flag;
  assign result.show_banner      = banner;

  // State update as the item moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st.on_flag        <= 1'b1;
      st.family_sel     <= 1'b1;
      st.pattern_reg    <= 3'd0;
      st.frame_reg      <= 4'd0;
      st.hue_reg        <= 8'd0;
      st.bright_reg     <= lsmc_pkg::BRIGHT_RESET;
      st.auto_flag      <= 1'b1;
      st.banner_pending <= 1'b0;
      st.ramp_active    <= 1'b0;
      st.ramp_up        <= 1'b1;
      st.minutes_run    <= 8'd0;
      st.bright_cnt     <= 8'd0;
      st.frame_cnt      <= 8'd0;
      st.pattern_cnt    <= 16'd0;
      st.family_cnt     <= 16'd0;
      st.minute_cnt     <= 12'd0;
    end else if (fire) begin
      st <= st_next;
    end
  end

endmodule

// File: rtl/led_show_mode_controller.sv
// Top level of the LED show mode controller: input register, core and result register.
`timescale 1ns / 1ps

// The controller takes one item (button event or base tick) per cycle while the result
// channel is not stalled, and returns one result item with the display state after it.
// An item is held in the input register, is applied to the mode state as it moves into
// the result register, and is offered on the result channel from then on. Back-to-back
// items sustain one per cycle while results are drained, as the next-state logic is
// combinational between the two registers. A new item is taken while a finished result
// waits, as long as the input register is free. Configuration writes are always
// accepted and take effect for the next item applied.
module led_show_mode_controller (
  input  logic        clk,
  input  logic        rst,
  lsmc_req_if.sink    req,
  lsmc_res_if.source  res,
  lsmc_cfg_if.sink    cfg
);

  lsmc_pkg::cfg_t regs;
  lsmc_pkg::res_t result;
  lsmc_pkg::res_t res_data;
  logic           q_valid;
  logic [2:0]     q_type;
  logic [3:0]     q_clicks;
  logic           advance;
  logic           res_valid;

  lsmc_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  lsmc_core u_core (
    .clk         (clk),
    .rst         (rst),
    .fire        (advance),
    .req_type    (q_type),
    .click_count (q_clicks),
    .regs        (regs),
    .result      (result)
  );

  // Handshake: the held item moves on when the result register is free or being drained.
  assign advance   = q_valid && (!res_valid || res.ready);
  assign req.ready = !q_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (req.ready) begin
      q_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      q_type   <= req.req_type;
      q_clicks <= req.click_count;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_data <= result;
    end
  end

  assign res.valid            = res_valid;
  assign res.display_on       = res_data.display_on;
  assign res.family           = res_data.family;
  assign res.pattern_index    = res_data.pattern_index;
  assign res.frame_index      = res_data.frame_index;
  assign res.base_hue         = res_data.base_hue;
  assign res.brightness_level = res_data.brightness_level;
  assign res.auto_mode        = res_data.auto_mode;
  assign res.show_banner      = res_data.show_banner;

endmodule
